[rtl/slsk_pkg.sv]
// shared types and constants of the sub-pixel line skew block
// no dependencies; used by every module under rtl
package slsk_pkg;

  // line size limit and derived widths
  localparam int MAX_LINE = 8192;
  localparam int POS_W    = $clog2(MAX_LINE);
  localparam int LEN_W    = POS_W + 1;
  // signed width that holds index plus shift without overflow
  localparam int SW       = LEN_W + 3;

  localparam int PIX_W    = 32;
  localparam int CH_W     = 8;
  localparam int NUM_CH   = PIX_W / CH_W;
  localparam int SHIFT_W  = 15;
  localparam int WGT_W    = 8;

  // stream payload widths
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W   = 2;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // result slots of one entry, in emission order
  localparam int NUM_SLOT  = 4;
  localparam int SLOT_LEAD = 0;
  localparam int SLOT_PIX  = 1;
  localparam int SLOT_TPIX = 2;
  localparam int SLOT_RUN  = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_LENGTH  = 2'd0,
    REG_OUT_LENGTH = 2'd1,
    REG_BACKGROUND = 2'd2
  } cfg_reg_t;

  // result kinds
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_RUN   = 1'b1
  } kind_t;

  typedef struct packed {
    logic [LEN_W-1:0] in_length;
    logic [LEN_W-1:0] out_length;
    logic [PIX_W-1:0] background;
  } cfg_t;

  // one classified source item as handed from front to back
  typedef struct packed {
    logic             lead_en;
    logic [LEN_W-1:0] lead_len;
    logic             pix_en;
    logic [POS_W-1:0] pix_pos;
    logic [PIX_W-1:0] pix_color;
    logic             tpix_en;
    logic [POS_W-1:0] tpix_pos;
    logic [PIX_W-1:0] tpix_color;
    logic             run_en;
    logic [POS_W-1:0] run_start;
    logic [LEN_W-1:0] run_len;
    logic [PIX_W-1:0] bg;
    logic             line_done;
  } entry_t;

  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] position;
    logic [LEN_W-1:0] run_length;
    logic [PIX_W-1:0] color;
    logic             last;
    logic             line_end;
  } res_t;

endpackage

[rtl/slsk_front.sv]
// front part: accepts source pixels, keeps line state, computes the skewed
// color and classifies the results of each item; uses slsk_pkg
module slsk_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  slsk_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  input  logic                        q_full,
  output logic                        in_ready,
  input  logic [slsk_pkg::PIX_W-1:0]  in_pixel,
  input  logic [slsk_pkg::SHIFT_W-1:0] in_shift,
  input  logic [slsk_pkg::WGT_W-1:0]  in_weight,
  output logic                        push,
  output slsk_pkg::entry_t            push_data
);

  localparam int SW    = slsk_pkg::SW;
  localparam int LEN_W = slsk_pkg::LEN_W;
  localparam int POS_W = slsk_pkg::POS_W;
  localparam int CH_W  = slsk_pkg::CH_W;

  logic [LEN_W-1:0]                 src_index_r, src_index_nxt;
  logic signed [slsk_pkg::SHIFT_W-1:0] line_shift_r, line_shift_nxt;
  logic [slsk_pkg::WGT_W-1:0]       line_weight_r, line_weight_nxt;
  logic [slsk_pkg::PIX_W-1:0]       prev_left_r, prev_left_nxt;

  logic                             accept;
  logic                             first;
  logic signed [slsk_pkg::SHIFT_W-1:0] sh;
  logic [slsk_pkg::WGT_W-1:0]       w;
  logic [slsk_pkg::PIX_W-1:0]       p;
  logic [slsk_pkg::PIX_W-1:0]       left;
  logic [slsk_pkg::PIX_W-1:0]       color;
  logic [LEN_W-1:0]                 lin;
  logic [LEN_W-1:0]                 lout;
  logic signed [SW-1:0]             sh_s, lin_s, lout_s, idx_s, pos_s, t_s, start_s;
  logic                             line_done;
  slsk_pkg::entry_t                 ent;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign first    = (src_index_r == '0);

  // line parameters: latched, or on a line start incoming shift, weight and background
  always_comb begin
    sh = first ? $signed(in_shift) : line_shift_r;
    w  = first ? in_weight : line_weight_r;
    p  = first ? cfg.background : prev_left_r;
  end

  // clamp lengths
  always_comb begin
    if (cfg.in_length == '0) begin
      lin = LEN_W'(1);
    end else if (cfg.in_length > LEN_W'(slsk_pkg::MAX_LINE)) begin
      lin = LEN_W'(slsk_pkg::MAX_LINE);
    end else begin
      lin = cfg.in_length;
    end
    if (cfg.out_length > LEN_W'(slsk_pkg::MAX_LINE)) begin
      lout = LEN_W'(slsk_pkg::MAX_LINE);
    end else begin
      lout = cfg.out_length;
    end
  end

  // per channel blend: left = (bg + (src - bg) * w) >> 8, pixel = src - left + prev
  always_comb begin
    logic [CH_W-1:0]   s, b, l;
    logic [2*CH_W-1:0] d, prod, v;
    for (int c = 0; c < slsk_pkg::NUM_CH; c++) begin
      s    = in_pixel[c*CH_W +: CH_W];
      b    = cfg.background[c*CH_W +: CH_W];
      d    = {{CH_W{1'b0}}, s} - {{CH_W{1'b0}}, b};
      prod = (2*CH_W)'(d * {{CH_W{1'b0}}, w});
      v    = {{CH_W{1'b0}}, b} + prod;
      l    = v[2*CH_W-1:CH_W];
      left[c*CH_W +: CH_W]  = l;
      color[c*CH_W +: CH_W] = s - l + p[c*CH_W +: CH_W];
    end
  end

  // positions and run bounds
  always_comb begin
    sh_s      = SW'(sh);
    lin_s     = $signed({{(SW-LEN_W){1'b0}}, lin});
    lout_s    = $signed({{(SW-LEN_W){1'b0}}, lout});
    idx_s     = $signed({{(SW-LEN_W){1'b0}}, src_index_r});
    pos_s     = idx_s + sh_s;
    t_s       = lin_s + sh_s;
    line_done = ({1'b0, src_index_r} + (LEN_W+1)'(1)) >= {1'b0, lin};
  end

  // classification of the results this item causes
  always_comb begin
    ent            = '0;
    ent.bg         = cfg.background;
    ent.line_done  = line_done;
    // leading background run on a line start with positive shift
    ent.lead_en    = first && (sh_s > 0) && (lout != '0);
    ent.lead_len   = (sh_s < lout_s) ? LEN_W'(sh_s) : lout;
    // pixel write when it lands on the line
    ent.pix_en     = (pos_s >= 0) && (pos_s < lout_s);
    ent.pix_pos    = POS_W'(pos_s);
    ent.pix_color  = color;
    // trailing pixel and trailing run at line end
    ent.tpix_en    = line_done && (t_s >= 0) && (t_s < lout_s);
    ent.tpix_pos   = POS_W'(t_s);
    ent.tpix_color = left;
    if ((t_s >= 0) && (t_s < lout_s)) begin
      start_s = t_s + SW'(1);
    end else if (t_s < 0) begin
      start_s = '0;
    end else begin
      start_s = t_s;
    end
    ent.run_en     = line_done && (start_s < lout_s);
    ent.run_start  = POS_W'(start_s);
    ent.run_len    = LEN_W'(lout_s - start_s);
  end

  // items that cause no result only advance state
  assign push      = accept && (ent.lead_en || ent.pix_en || ent.tpix_en || ent.run_en);
  assign push_data = ent;

  // line state next values
  always_comb begin
    src_index_nxt   = src_index_r;
    line_shift_nxt  = line_shift_r;
    line_weight_nxt = line_weight_r;
    prev_left_nxt   = prev_left_r;
    if (accept) begin
      src_index_nxt   = line_done ? '0 : src_index_r + LEN_W'(1);
      line_shift_nxt  = sh;
      line_weight_nxt = w;
      prev_left_nxt   = left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_index_r   <= '0;
      line_shift_r  <= '0;
      line_weight_r <= '0;
    end else begin
      src_index_r   <= src_index_nxt;
      line_shift_r  <= line_shift_nxt;
      line_weight_r <= line_weight_nxt;
    end
  end

  // carried color needs no reset: reloaded on every line start
  always_ff @(posedge clk) begin
    prev_left_r <= prev_left_nxt;
  end

endmodule

[rtl/slsk_queue.sv]
// short queue of classified items between front and back
// uses slsk_pkg for the entry type and depth
module slsk_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  slsk_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output slsk_pkg::entry_t head
);

  localparam int PW = slsk_pkg::Q_PTR_W;
  localparam int CW = slsk_pkg::Q_CNT_W;

  slsk_pkg::entry_t  mem_r [slsk_pkg::Q_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  assign full  = (count_r == CW'(slsk_pkg::Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // pointer wrap at queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(slsk_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(slsk_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/slsk_back.sv]
// back part: expands the queue head into its results, one per cycle while
// the output is not stalled, into the output register; uses slsk_pkg
module slsk_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             empty,
  input  slsk_pkg::entry_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output slsk_pkg::res_t   out_res
);

  localparam int NS = slsk_pkg::NUM_SLOT;

  logic [NS-1:0]    done_r, done_nxt;
  logic             out_valid_r, out_valid_nxt;
  slsk_pkg::res_t   res_r, res_nxt;

  logic [NS-1:0]    en;
  logic [NS-1:0]    pending;
  logic [NS-1:0]    pick;
  logic             final_res;
  logic             load;
  slsk_pkg::res_t   cand [NS];

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // candidate results of the head entry
  always_comb begin
    en[slsk_pkg::SLOT_LEAD] = head.lead_en;
    en[slsk_pkg::SLOT_PIX]  = head.pix_en;
    en[slsk_pkg::SLOT_TPIX] = head.tpix_en;
    en[slsk_pkg::SLOT_RUN]  = head.run_en;

    cand[slsk_pkg::SLOT_LEAD] = '{kind: slsk_pkg::KIND_RUN, position: '0,
                                  run_length: head.lead_len, color: head.bg,
                                  last: 1'b0, line_end: 1'b0};
    cand[slsk_pkg::SLOT_PIX]  = '{kind: slsk_pkg::KIND_PIXEL, position: head.pix_pos,
                                  run_length: slsk_pkg::LEN_W'(1),
                                  color: head.pix_color, last: 1'b0, line_end: 1'b0};
    cand[slsk_pkg::SLOT_TPIX] = '{kind: slsk_pkg::KIND_PIXEL, position: head.tpix_pos,
                                  run_length: slsk_pkg::LEN_W'(1),
                                  color: head.tpix_color, last: 1'b0, line_end: 1'b0};
    cand[slsk_pkg::SLOT_RUN]  = '{kind: slsk_pkg::KIND_RUN, position: head.run_start,
                                  run_length: head.run_len, color: head.bg,
                                  last: 1'b0, line_end: 1'b0};
  end

  // first pending slot in emission order
  always_comb begin
    pending = en & ~done_r;
    pick    = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        pick    = '0;
        pick[i] = 1'b1;
      end
    end
    final_res = ((pending & ~pick) == '0);
  end

  // load output register from a non-empty queue when it is free or being drained
  always_comb begin
    load          = !empty && (!out_valid_r || out_ready);
    pop           = load && final_res;
    out_valid_nxt = out_valid_r;
    done_nxt      = done_r;
    res_nxt       = res_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      done_nxt      = final_res ? '0 : (done_r | pick);
      for (int i = 0; i < NS; i++) begin
        if (pick[i]) begin
          res_nxt = cand[i];
        end
      end
      res_nxt.last     = final_res;
      res_nxt.line_end = final_res && head.line_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

[rtl/subpixel_line_skew.sv]
// top level of the sub-pixel line skew block: configuration registers,
// front, queue and back; uses slsk_pkg, slsk_front, slsk_queue, slsk_back
//
//  channel  direction  handshake                 payload
//  in_      slave      in_tvalid / in_tready     in_tdata
//  out_     master     out_tvalid / out_tready   out_tdata, out_tuser, out_tlast
//  cfg_     slave      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one source pixel is taken per cycle while the queue is not full; it goes
// through the queue into the output register. a pixel that starts or ends
// a line gives up to four results, emitted one at a time while the two-entry
// queue absorbs the front. reset is synchronous and clears line state and
// queue; no memory needs a clearing pass. configuration writes complete at once.
module subpixel_line_skew (
  input  logic                                clk,
  input  logic                                rst_n,
  // [31:0] pixel, [46:32] shift, [54:47] frac_weight
  input  logic [slsk_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [12:0] position, [26:13] run_length, [58:27] color, [59] last
  output logic [slsk_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] kind
  output logic                                out_tuser,
  output logic                                out_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [slsk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slsk_pkg::PIX_W-1:0]          cfg_data
);

  localparam int LEN_W = slsk_pkg::LEN_W;

  slsk_pkg::cfg_t   cfg_r, cfg_nxt;
  logic             q_full, q_empty, push, pop;
  slsk_pkg::entry_t push_data, head;
  slsk_pkg::res_t   res;

  assign cfg_ready = 1'b1;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (slsk_pkg::cfg_reg_t'(cfg_index))
        slsk_pkg::REG_IN_LENGTH:  cfg_nxt.in_length  = cfg_data[LEN_W-1:0];
        slsk_pkg::REG_OUT_LENGTH: cfg_nxt.out_length = cfg_data[LEN_W-1:0];
        slsk_pkg::REG_BACKGROUND: cfg_nxt.background = cfg_data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_length  <= LEN_W'(slsk_pkg::MAX_LINE);
      cfg_r.out_length <= LEN_W'(slsk_pkg::MAX_LINE);
      cfg_r.background <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  slsk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .q_full    (q_full),
    .in_ready  (in_tready),
    .in_pixel  (in_tdata[31:0]),
    .in_shift  (in_tdata[46:32]),
    .in_weight (in_tdata[54:47]),
    .push      (push),
    .push_data (push_data)
  );

  slsk_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  slsk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // result packing
  assign out_tdata = {4'b0, res.last, res.color, res.run_length, res.position};
  assign out_tuser = res.kind;
  assign out_tlast = res.line_end;

endmodule
